FILE: hw/rtl/npt_pkg.sv
// shared types, constants and table functions of the nco pll phase tracker
package npt_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int WORD_W    = 31;
    localparam int MUL_A_W   = 18;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int RND_W     = PROD_W - 14;
    localparam int SUM_W     = RND_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FREQ = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMP      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THRESH  = 4'd7;

    localparam logic [15:0] FILTER_COEFF_RESET = 16'd32768;
    localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [PROD_W-1:0] ROUND_HALF   = PROD_W'(16384);
    localparam logic [15:0] AMP_MAX            = 16'd32768;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SIN,
        OP_COS,
        OP_AF,
        OP_RAW,
        OP_EF,
        OP_INT,
        OP_PROP
    } t_mul_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN,
        ST_COS,
        ST_AF,
        ST_RAW,
        ST_WAIT_RAW,
        ST_EF,
        ST_WAIT_EF,
        ST_INT,
        ST_WAIT_INT,
        ST_PROP,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_mul_op mul_op;
        logic    load_sample;
        logic    restart;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic signed [15:0] quarter_sine(input logic [6:0] off);
        logic signed [15:0] v;
        case (off)
            7'd0:  v = 16'sd0;     7'd1:  v = 16'sd804;   7'd2:  v = 16'sd1608;
            7'd3:  v = 16'sd2410;  7'd4:  v = 16'sd3212;  7'd5:  v = 16'sd4011;
            7'd6:  v = 16'sd4808;  7'd7:  v = 16'sd5602;  7'd8:  v = 16'sd6393;
            7'd9:  v = 16'sd7179;  7'd10: v = 16'sd7962;  7'd11: v = 16'sd8739;
            7'd12: v = 16'sd9512;  7'd13: v = 16'sd10278; 7'd14: v = 16'sd11039;
            7'd15: v = 16'sd11793; 7'd16: v = 16'sd12539; 7'd17: v = 16'sd13279;
            7'd18: v = 16'sd14010; 7'd19: v = 16'sd14732; 7'd20: v = 16'sd15446;
            7'd21: v = 16'sd16151; 7'd22: v = 16'sd16846; 7'd23: v = 16'sd17530;
            7'd24: v = 16'sd18204; 7'd25: v = 16'sd18868; 7'd26: v = 16'sd19519;
            7'd27: v = 16'sd20159; 7'd28: v = 16'sd20787; 7'd29: v = 16'sd21403;
            7'd30: v = 16'sd22005; 7'd31: v = 16'sd22594; 7'd32: v = 16'sd23170;
            7'd33: v = 16'sd23731; 7'd34: v = 16'sd24279; 7'd35: v = 16'sd24811;
            7'd36: v = 16'sd25329; 7'd37: v = 16'sd25832; 7'd38: v = 16'sd26319;
            7'd39: v = 16'sd26790; 7'd40: v = 16'sd27245; 7'd41: v = 16'sd27683;
            7'd42: v = 16'sd28105; 7'd43: v = 16'sd28510; 7'd44: v = 16'sd28898;
            7'd45: v = 16'sd29268; 7'd46: v = 16'sd29621; 7'd47: v = 16'sd29956;
            7'd48: v = 16'sd30273; 7'd49: v = 16'sd30571; 7'd50: v = 16'sd30852;
            7'd51: v = 16'sd31113; 7'd52: v = 16'sd31356; 7'd53: v = 16'sd31580;
            7'd54: v = 16'sd31785; 7'd55: v = 16'sd31971; 7'd56: v = 16'sd32137;
            7'd57: v = 16'sd32285; 7'd58: v = 16'sd32412; 7'd59: v = 16'sd32521;
            7'd60: v = 16'sd32609; 7'd61: v = 16'sd32678; 7'd62: v = 16'sd32728;
            7'd63: v = 16'sd32757; 7'd64: v = 16'sd32767;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] table_at(input logic [7:0] idx);
        logic [6:0] off;
        logic [6:0] mirror;
        logic signed [15:0] v;
        off    = {1'b0, idx[5:0]};
        mirror = 7'd64 - off;
        case (idx[7:6])
            2'd0:    v = quarter_sine(off);
            2'd1:    v = quarter_sine(mirror);
            2'd2:    v = -quarter_sine(off);
            default: v = -quarter_sine(mirror);
        endcase
        return v;
    endfunction

    // scale by 2^-15, half away from zero
    function automatic logic signed [RND_W-1:0] q15_round(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] q;
        m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        q = (m + ROUND_HALF) >> 15;
        return p[PROD_W-1] ? -$signed(q[RND_W-1:0]) : $signed(q[RND_W-1:0]);
    endfunction

endpackage

FILE: hw/rtl/nco_pll_phase_tracker.sv
// digital pll with nco and lock detector, top level
// a sample request runs the sin, cos, amplitude, raw error, error filter, integral and
// phase steps from acceptance to result valid; one at a time, as the dependent products
// share the one 18x33 multiplier; the phase step waits while an earlier result is held
// in the result register; a restart request gives no result
// synchronous active-low reset clears loop state, configuration and result valid
module nco_pll_phase_tracker
    import npt_pkg::*;
#(
    parameter int LOCK_COUNT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic signed [15:0]   i_sample,
    input  logic [31:0]          i_start_phase,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_ref_phase,
    output logic signed [15:0]   o_sine_out,
    output logic signed [15:0]   o_cosine_out,
    output logic signed [15:0]   o_phase_error,
    output logic [15:0]          o_amplitude,
    output logic [30:0]          o_freq_word,
    output logic                 o_locked,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_index,
    input  logic [30:0]          i_cfg_data
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    npt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    npt_datapath #(
        .LOCK_COUNT (LOCK_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_sample      (i_sample),
        .i_start_phase (i_start_phase),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_ref_phase   (o_ref_phase),
        .o_sine_out    (o_sine_out),
        .o_cosine_out  (o_cosine_out),
        .o_phase_error (o_phase_error),
        .o_amplitude   (o_amplitude),
        .o_freq_word   (o_freq_word),
        .o_locked      (o_locked)
    );

endmodule

FILE: hw/rtl/npt_ctrl.sv
// sequencer of the shared multiplier for one sample
module npt_ctrl
    import npt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_action,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_ctl_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '{mul_op: OP_NONE, load_sample: 1'b0, restart: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action) begin
                        o_cmd.restart = 1'b1;
                    end else begin
                        o_cmd.load_sample = 1'b1;
                        n_state = ST_SIN;
                    end
                end
            end
            ST_SIN: begin
                o_cmd.mul_op = OP_SIN;
                n_state = ST_COS;
            end
            ST_COS: begin
                o_cmd.mul_op = OP_COS;
                n_state = ST_AF;
            end
            ST_AF: begin
                o_cmd.mul_op = OP_AF;
                n_state = ST_RAW;
            end
            ST_RAW: begin
                o_cmd.mul_op = OP_RAW;
                n_state = ST_WAIT_RAW;
            end
            ST_WAIT_RAW: begin
                n_state = ST_EF;
            end
            ST_EF: begin
                o_cmd.mul_op = OP_EF;
                n_state = ST_WAIT_EF;
            end
            ST_WAIT_EF: begin
                n_state = ST_INT;
            end
            ST_INT: begin
                o_cmd.mul_op = OP_INT;
                n_state = ST_WAIT_INT;
            end
            ST_WAIT_INT: begin
                n_state = ST_PROP;
            end
            ST_PROP: begin
                if (i_status.out_free) begin
                    o_cmd.mul_op = OP_PROP;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/npt_datapath.sv
// loop state, configuration, shared multiplier and result register
module npt_datapath
    import npt_pkg::*;
#(
    parameter int LOCK_COUNT = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl_cmd                i_cmd,
    output t_dp_status              o_status,
    input  logic signed [15:0]      i_sample,
    input  logic [31:0]             i_start_phase,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [WORD_W-1:0]       i_cfg_data,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [31:0]             o_ref_phase,
    output logic signed [15:0]      o_sine_out,
    output logic signed [15:0]      o_cosine_out,
    output logic signed [15:0]      o_phase_error,
    output logic [15:0]             o_amplitude,
    output logic [WORD_W-1:0]       o_freq_word,
    output logic                    o_locked
);

    localparam int CNT_W = $clog2(LOCK_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LOCK_COUNT);

    logic [WORD_W-1:0] r_init_freq, r_min_freq, r_max_freq, r_prop_gain, r_int_gain;
    logic [15:0]       r_coeff, r_min_amp, r_lock_thr;

    logic [31:0]        r_phase;
    logic [WORD_W-1:0]  r_freq;
    logic signed [15:0] r_ef;
    logic [15:0]        r_af;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_lock;
    logic signed [15:0] r_sample, r_sin, r_cos, r_raw;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [15:0]       r_base;
    t_mul_op                  r_pop;

    logic                     r_out_valid;
    logic [31:0]              r_out_phase;
    logic signed [15:0]       r_out_sin, r_out_cos, r_out_ef;
    logic [15:0]              r_out_af;
    logic [WORD_W-1:0]        r_out_freq;
    logic                     r_out_lock;

    logic [31:0]              lut_phase;
    logic signed [15:0]       lut_a, lut_b;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [RND_W-1:0]   rnd;
    logic signed [SUM_W-1:0]   sum;
    logic [15:0]               abs_ef;
    logic [CNT_W-1:0]          cnt_up;
    logic                      good;

    // sine table lookup
    assign lut_phase = (i_cmd.mul_op == OP_COS) ? r_phase + QUARTER_TURN : r_phase;
    assign lut_a     = table_at(lut_phase[31:24]);
    assign lut_b     = table_at(lut_phase[31:24] + 8'd1);

    always_comb begin
        case (i_cmd.mul_op)
            OP_SIN, OP_COS: begin
                mul_a = MUL_A_W'(lut_b) - MUL_A_W'(lut_a);
                mul_b = $signed({18'd0, lut_phase[23:9]});
            end
            OP_AF: begin
                mul_a = $signed({1'b0, (r_sample[15] ? 16'(-r_sample) : 16'(r_sample))})
                        - $signed({2'b00, r_af});
                mul_b = $signed({17'd0, r_coeff});
            end
            OP_RAW: begin
                mul_a = MUL_A_W'(r_sample);
                mul_b = MUL_B_W'(r_cos);
            end
            OP_EF: begin
                mul_a = MUL_A_W'(r_raw) - MUL_A_W'(r_ef);
                mul_b = $signed({17'd0, r_coeff});
            end
            OP_INT: begin
                mul_a = MUL_A_W'(r_ef);
                mul_b = $signed({2'b00, r_int_gain});
            end
            OP_PROP: begin
                mul_a = MUL_A_W'(r_ef);
                mul_b = $signed({2'b00, r_prop_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign rnd   = q15_round(r_prod);

    always_comb begin
        case (r_pop)
            OP_AF:   sum = SUM_W'(rnd) + $signed({{(SUM_W-16){1'b0}}, r_af});
            OP_EF:   sum = SUM_W'(rnd) + SUM_W'(r_ef);
            OP_INT,
            OP_PROP: sum = SUM_W'(rnd) + $signed({{(SUM_W-WORD_W){1'b0}}, r_freq});
            default: sum = SUM_W'(rnd) + SUM_W'(r_base);
        endcase
    end

    assign abs_ef = r_ef[15] ? 16'(-r_ef) : 16'(r_ef);
    assign good   = (r_af >= r_min_amp) && (abs_ef <= r_lock_thr);
    assign cnt_up = (r_cnt < CNT_MAX) ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_freq <= '0;
            r_min_freq  <= '0;
            r_max_freq  <= '0;
            r_prop_gain <= '0;
            r_int_gain  <= '0;
            r_coeff     <= FILTER_COEFF_RESET;
            r_min_amp   <= '0;
            r_lock_thr  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INITIAL_FREQ: r_init_freq <= i_cfg_data;
                CFG_MIN_FREQ:     r_min_freq  <= i_cfg_data;
                CFG_MAX_FREQ:     r_max_freq  <= i_cfg_data;
                CFG_PROP_GAIN:    r_prop_gain <= i_cfg_data;
                CFG_INT_GAIN:     r_int_gain  <= i_cfg_data;
                CFG_FILTER_COEFF: r_coeff     <= i_cfg_data[15:0];
                CFG_MIN_AMP:      r_min_amp   <= i_cfg_data[15:0];
                CFG_LOCK_THRESH:  r_lock_thr  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        r_base <= lut_a;
        if (i_cmd.load_sample) begin
            r_sample <= i_sample;
        end
        if (r_pop == OP_SIN) begin
            r_sin <= sum[15:0];
        end
        if (r_pop == OP_COS) begin
            r_cos <= sum[15:0];
        end
        if (r_pop == OP_RAW) begin
            r_raw <= rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop   <= OP_NONE;
            r_phase <= '0;
            r_freq  <= '0;
            r_ef    <= '0;
            r_af    <= '0;
            r_cnt   <= '0;
            r_lock  <= 1'b0;
        end else begin
            r_pop <= i_cmd.mul_op;
            if (i_cmd.restart) begin
                r_phase <= i_start_phase;
                r_freq  <= r_init_freq;
                r_ef    <= '0;
                r_af    <= '0;
                r_cnt   <= '0;
                r_lock  <= 1'b0;
            end
            case (r_pop)
                OP_AF: begin
                    if (sum < 0) begin
                        r_af <= '0;
                    end else if (sum > $signed({{(SUM_W-16){1'b0}}, AMP_MAX})) begin
                        r_af <= AMP_MAX;
                    end else begin
                        r_af <= sum[15:0];
                    end
                end
                OP_EF: begin
                    if (sum < -SUM_W'(32768)) begin
                        r_ef <= 16'sh8000;
                    end else if (sum > SUM_W'(32767)) begin
                        r_ef <= 16'sh7fff;
                    end else begin
                        r_ef <= sum[15:0];
                    end
                end
                OP_INT: begin
                    if (sum < $signed({{(SUM_W-WORD_W){1'b0}}, r_min_freq})) begin
                        r_freq <= r_min_freq;
                    end else if (sum > $signed({{(SUM_W-WORD_W){1'b0}}, r_max_freq})) begin
                        r_freq <= r_max_freq;
                    end else begin
                        r_freq <= sum[WORD_W-1:0];
                    end
                end
                OP_PROP: begin
                    if (sum < 0) begin
                        r_phase <= r_phase;
                    end else if (sum > $signed({{(SUM_W-32){1'b0}}, 32'hffff_ffff})) begin
                        r_phase <= r_phase + 32'hffff_ffff;
                    end else begin
                        r_phase <= r_phase + sum[31:0];
                    end
                    if (good) begin
                        r_cnt  <= cnt_up;
                        r_lock <= r_lock || (cnt_up >= CNT_MAX);
                    end else begin
                        r_cnt  <= '0;
                        r_lock <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pop == OP_PROP) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pop == OP_PROP) begin
            r_out_phase <= r_phase;
            r_out_sin   <= r_sin;
            r_out_cos   <= r_cos;
            r_out_ef    <= r_ef;
            r_out_af    <= r_af;
            r_out_freq  <= r_freq;
            r_out_lock  <= good && (r_lock || (cnt_up >= CNT_MAX));
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_ref_phase   = r_out_phase;
    assign o_sine_out    = r_out_sin;
    assign o_cosine_out  = r_out_cos;
    assign o_phase_error = r_out_ef;
    assign o_amplitude   = r_out_af;
    assign o_freq_word   = r_out_freq;
    assign o_locked      = r_out_lock;

endmodule

FILE: hw/rtl/npt_checker.sv
// port-level checks of the phase tracker and their bind
module npt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_action,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [31:0]        o_ref_phase,
    input logic signed [15:0] o_sine_out,
    input logic [15:0]        o_amplitude
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ref_phase))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_action |=> !o_in_ready)
        else $error("sample request accepted while busy");

    a_amp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_amplitude <= 16'd32768)
        else $error("amplitude out of range");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sine_out != 16'sh8000)
        else $error("sine out of range");

endmodule

bind nco_pll_phase_tracker npt_checker u_npt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_ref_phase (o_ref_phase),
    .o_sine_out  (o_sine_out),
    .o_amplitude (o_amplitude)
);
